/* rtl/ppu_vmm_pkg.sv */
`default_nettype none

package ppu_vmm_pkg;

   // Fixed sizes of the name-table and palette stores
   localparam int NAMETABLE_DEPTH = 4096;
   localparam int PALETTE_ENTRIES = 32;
   localparam int NT_AW           = 12;
   localparam int PAL_AW          = 5;

   // Default pattern store depth
   localparam int PATTERN_DEPTH_DEF = 8192;

   // Access codes of an item
   typedef enum logic [1:0] {
      MODE_READ     = 2'd0,
      MODE_WRITE    = 2'd1,
      MODE_BUF_READ = 2'd2,
      MODE_RSVD     = 2'd3
   } mode_type;

   // Name-table mirroring codes
   typedef enum logic [1:0] {
      MIRROR_HORIZ = 2'd0,
      MIRROR_VERT  = 2'd1,
      MIRROR_NONE  = 2'd2,
      MIRROR_RSVD  = 2'd3
   } mirror_type;

   // Store that an access lands in
   typedef enum logic [1:0] {
      TGT_PATTERN   = 2'd0,
      TGT_NAMETABLE = 2'd1,
      TGT_PALETTE   = 2'd2,
      TGT_NONE      = 2'd3
   } target_type;

   // Decoded access handed from the decoder to the stores
   typedef struct packed {
      target_type         target;
      logic               is_write;
      logic [NT_AW-1:0]   nt_index;
      logic [PAL_AW-1:0]  pal_index;
   } access_type;

endpackage

`default_nettype wire

/* rtl/ppu_vmm_ram.sv */
`default_nettype none

module ppu_vmm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ppu_vmm_decode.sv */
`default_nettype none

module ppu_vmm_decode #(
   parameter int PATTERN_DEPTH = ppu_vmm_pkg::PATTERN_DEPTH_DEF
) (
   input  wire logic [1:0]                       mode,
   input  wire logic [13:0]                      addr,
   input  wire ppu_vmm_pkg::mirror_type          mirroring,
   output ppu_vmm_pkg::access_type               access,
   output logic      [$clog2(PATTERN_DEPTH)-1:0] pat_index
);

   import ppu_vmm_pkg::*;

   localparam int PatAw = $clog2(PATTERN_DEPTH);
   localparam logic [15:0] Dep1 = 16'(PATTERN_DEPTH);
   localparam logic [15:0] Dep2 = 16'(2 * PATTERN_DEPTH);
   localparam logic [15:0] Dep4 = 16'(4 * PATTERN_DEPTH);

   logic             is_pattern;
   logic             is_palette;
   logic [NT_AW-1:0] nt_off;
   logic [15:0]      pr0, pr1, pr2, pr3;

   assign is_pattern = ~addr[13];
   assign is_palette = (addr[13:8] == 6'h3F);

   // Decoded access, built in one place
   always_comb begin
      // Store selection; a buffered palette read goes to the name table underneath
      access.is_write = (mode_type'(mode) == MODE_WRITE);
      if (is_pattern) begin
         access.target = TGT_PATTERN;
      end else if (is_palette && !(mode_type'(mode) == MODE_BUF_READ)) begin
         access.target = TGT_PALETTE;
      end else begin
         access.target = TGT_NAMETABLE;
      end

      // Name-table folding of the low 12 bits: horiz clears bit 10, vert bit 11
      nt_off = addr[NT_AW-1:0];
      case (mirroring)
         MIRROR_HORIZ: nt_off[10] = 1'b0;
         MIRROR_VERT:  nt_off[11] = 1'b0;
         default:      nt_off = addr[NT_AW-1:0];
      endcase
      access.nt_index = nt_off;

      // Palette index, sprite backdrop entries alias onto background entries
      access.pal_index = addr[PAL_AW-1:0];
      if (addr[4] && (addr[1:0] == 2'b00)) begin
         access.pal_index[4] = 1'b0;
      end
   end

   // Pattern wrap: value stays below 8x depth, three compare-subtract steps
   always_comb begin
      pr0 = {3'b000, addr[12:0]};
      pr1 = (pr0 >= Dep4) ? pr0 - Dep4 : pr0;
      pr2 = (pr1 >= Dep2) ? pr1 - Dep2 : pr1;
      pr3 = (pr2 >= Dep1) ? pr2 - Dep1 : pr2;
      pat_index = pr3[PatAw-1:0];
   end

endmodule

`default_nettype wire

/* rtl/ppu_video_memory_map.sv */
// Video memory map of a picture unit: one 14-bit access per item.
// Request channel: req_valid/req_stall with req_mode (0 read, 1 write,
// 2 buffered read), req_addr and req_write_data. Response channel:
// rsp_valid/rsp_stall with rsp_read_data, one response per request, in
// order; a write responds with zero.
// Configuration: csr_valid/csr_ready with csr_write_data, the name-table
// mirroring code (0 horizontal, 1 vertical, 2 none). Write it only while
// no request is outstanding. csr_ready is always high.
// Response: valid in the cycle after its request is accepted.
// Throughput: one item per cycle unless req_stall is high; the address
// decode and the registered read of the single-port store set that rate.
// Stall: while a response is held by rsp_stall, req_stall is raised and
// the response and the read registers hold their value.
// Reset: clears the response valid and sets mirroring to horizontal. The
// stores are not cleared; read only what has been written.
`default_nettype none

module ppu_video_memory_map #(
   parameter int PATTERN_DEPTH = ppu_vmm_pkg::PATTERN_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [13:0] req_addr,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_read_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_write_data
);

   import ppu_vmm_pkg::*;

   localparam int PatAw = $clog2(PATTERN_DEPTH);

   mirror_type       mirroring_ff, mirroring_in;
   logic             rsp_valid_ff, rsp_valid_in;
   target_type       rsp_target_ff, rsp_target_in;
   logic             rsp_zero_ff, rsp_zero_in;
   logic             req_accept;
   access_type       access;
   logic [PatAw-1:0] pat_index;
   logic [7:0]       pat_rd_data, nt_rd_data, pal_rd_data;
   logic             pat_sel, nt_sel, pal_sel;

   // Configuration register
   assign csr_ready = 1'b1;
   assign mirroring_in = (csr_valid && csr_ready) ? mirror_type'(csr_write_data) : mirroring_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirroring_ff <= MIRROR_HORIZ;
      end else begin
         mirroring_ff <= mirroring_in;
      end
   end

   // Request handshake
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   ppu_vmm_decode #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) u_decode (
      .mode      (req_mode),
      .addr      (req_addr),
      .mirroring (mirroring_ff),
      .access    (access),
      .pat_index (pat_index)
   );

   assign pat_sel = req_accept && (access.target == TGT_PATTERN);
   assign nt_sel  = req_accept && (access.target == TGT_NAMETABLE);
   assign pal_sel = req_accept && (access.target == TGT_PALETTE);

   // Stores
   ppu_vmm_ram #(
      .DEPTH(PATTERN_DEPTH),
      .WIDTH(8)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_sel && access.is_write),
      .rd_en   (pat_sel && !access.is_write),
      .addr    (pat_index),
      .wr_data (req_write_data),
      .rd_data (pat_rd_data)
   );

   ppu_vmm_ram #(
      .DEPTH(NAMETABLE_DEPTH),
      .WIDTH(8)
   ) u_nametable_ram (
      .clock   (clock),
      .wr_en   (nt_sel && access.is_write),
      .rd_en   (nt_sel && !access.is_write),
      .addr    (access.nt_index),
      .wr_data (req_write_data),
      .rd_data (nt_rd_data)
   );

   ppu_vmm_ram #(
      .DEPTH(PALETTE_ENTRIES),
      .WIDTH(8)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_sel && access.is_write),
      .rd_en   (pal_sel && !access.is_write),
      .addr    (access.pal_index),
      .wr_data (req_write_data),
      .rd_data (pal_rd_data)
   );

   // Response control
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_target_in = rsp_target_ff;
      rsp_zero_in   = rsp_zero_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_target_in = access.target;
         rsp_zero_in   = access.is_write;
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_target_ff <= rsp_target_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   // Result select from the store read registers
   always_comb begin
      if (rsp_zero_ff) begin
         rsp_read_data = 8'h00;
      end else begin
         case (rsp_target_ff)
            TGT_PATTERN:   rsp_read_data = pat_rd_data;
            TGT_NAMETABLE: rsp_read_data = nt_rd_data;
            TGT_PALETTE:   rsp_read_data = pal_rd_data;
            default:       rsp_read_data = 8'h00;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Every accepted item shows a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item produced no response");

   // A write responds with zero
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_mode == MODE_WRITE)) |=> (rsp_read_data == 8'h00))
      else $error("write response not zero");

   // No item enters while a response is held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !req_accept)
      else $error("item accepted over a held response");

   // A response leaves only when it has been taken
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("response dropped while stalled");
`endif

endmodule

`default_nettype wire
